@@ design/lppr_pkg.sv @@
// Shared types and constants of the length-prefixed packet ring.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lppr_pkg;

    localparam int KIND_W         = 3;
    localparam int LEN_W          = 12;
    localparam int BYTE_W         = 8;
    localparam int STATUS_W       = 3;
    localparam int HDR_BYTES      = 4;
    localparam int RING_BYTES_DEF = 4096;
    localparam int QUEUE_DEPTH    = 2;

    // Raw item kinds as they arrive on the input channel
    localparam logic [KIND_W-1:0] KIND_BEGIN = 3'd0;
    localparam logic [KIND_W-1:0] KIND_WRITE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_OPEN  = 3'd2;
    localparam logic [KIND_W-1:0] KIND_READ  = 3'd3;
    localparam logic [KIND_W-1:0] KIND_PEEK  = 3'd4;
    localparam logic [KIND_W-1:0] KIND_SKIP  = 3'd5;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 3'd6;

    // Decoded operation handed from the front to the back
    typedef enum logic [2:0] {
        OP_BEGIN,
        OP_WRITE,
        OP_OPEN,
        OP_READ,
        OP_PEEK,
        OP_SKIP,
        OP_CLEAR,
        OP_NOP
    } t_op;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK         = 3'd0,
        ST_ZERO       = 3'd1,
        ST_NOROOM     = 3'd2,
        ST_EMPTY      = 3'd3,
        ST_INCOMPLETE = 3'd4,
        ST_SEQ        = 3'd5,
        ST_SKIP       = 3'd6
    } t_status;

    typedef struct packed {
        t_op               op;
        logic [LEN_W-1:0]  length;
        logic [BYTE_W-1:0] data;
    } t_cmd;

endpackage

@@ design/lppr_if.sv @@
// Channel interfaces of the packet ring: command beats in, result beats out.
// Depends on lppr_pkg for the field widths.
`timescale 1ns / 1ps

interface lppr_in_if import lppr_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] kind;
    logic [LEN_W-1:0]  length;
    logic [BYTE_W-1:0] data_byte;

    modport source (output valid, kind, length, data_byte, input ready);
    modport sink   (input valid, kind, length, data_byte, output ready);
endinterface

interface lppr_out_if import lppr_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [LEN_W-1:0]    packet_length;
    logic [BYTE_W-1:0]   read_byte;
    logic                last_byte;
    logic [LEN_W-1:0]    free_space;
    logic [LEN_W-1:0]    used_space;
    logic                ring_empty;
    logic                is_full;

    modport source (output valid, status, packet_length, read_byte, last_byte,
                    free_space, used_space, ring_empty, is_full, input ready);
    modport sink   (input valid, status, packet_length, read_byte, last_byte,
                    free_space, used_space, ring_empty, is_full, output ready);
endinterface

@@ design/lppr_front.sv @@
// Front end of the packet ring: accepts command beats, decodes the kind and
// queues decoded commands for the back end. Depends on lppr_pkg, lppr_if.
`timescale 1ns / 1ps

module lppr_front import lppr_pkg::*; (
    input  logic         i_clk,
    input  logic         i_rst_n,
    lppr_in_if.sink      i_in,
    input  logic         i_pop,
    output logic         o_cmd_valid,
    output t_cmd         o_cmd
);

    localparam int QW   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNTW = QW + 1;

    t_cmd            r_q [QUEUE_DEPTH];
    logic [QW-1:0]   r_wr;
    logic [QW-1:0]   r_rd;
    logic [CNTW-1:0] r_cnt;

    t_op  w_op;
    logic w_push;

    always_comb begin
        unique case (i_in.kind)
            KIND_BEGIN: w_op = OP_BEGIN;
            KIND_WRITE: w_op = OP_WRITE;
            KIND_OPEN:  w_op = OP_OPEN;
            KIND_READ:  w_op = OP_READ;
            KIND_PEEK:  w_op = OP_PEEK;
            KIND_SKIP:  w_op = OP_SKIP;
            KIND_CLEAR: w_op = OP_CLEAR;
            default:    w_op = OP_NOP;
        endcase
    end

    assign i_in.ready  = (r_cnt != CNTW'(QUEUE_DEPTH));
    assign w_push      = i_in.valid && i_in.ready;
    assign o_cmd_valid = (r_cnt != '0);
    assign o_cmd       = r_q[r_rd];

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_q[r_wr] <= '{op: w_op, length: i_in.length, data: i_in.data_byte};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (w_push) begin
                r_wr <= (r_wr == QW'(QUEUE_DEPTH - 1)) ? '0 : r_wr + QW'(1);
            end
            if (i_pop) begin
                r_rd <= (r_rd == QW'(QUEUE_DEPTH - 1)) ? '0 : r_rd + QW'(1);
            end
            // pop is only raised while the queue holds a command
            if (w_push && !i_pop) begin
                r_cnt <= r_cnt + CNTW'(1);
            end else if (!w_push && i_pop) begin
                r_cnt <= r_cnt - CNTW'(1);
            end
        end
    end

endmodule

@@ design/lppr_back.sv @@
// Back end of the packet ring: pointer state, byte memory and the command
// sequencer that builds one result beat per command. Depends on lppr_pkg, lppr_if.
`timescale 1ns / 1ps

module lppr_back import lppr_pkg::*; #(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_cmd_valid,
    input  t_cmd      i_cmd,
    output logic      o_pop,
    lppr_out_if.source o_out
);

    localparam int IW = $clog2(RING_BYTES);
    localparam int PW = IW + 1;
    localparam int CW = ((PW > LEN_W) ? PW : LEN_W) + 2;
    localparam int HW = 8 * HDR_BYTES;

    typedef enum logic [1:0] {
        S_IDLE,
        S_HWR,
        S_HRD,
        S_BRD
    } t_state;

    logic [BYTE_W-1:0] r_mem [RING_BYTES];
    logic [BYTE_W-1:0] r_mem_q;

    t_state          r_state, n_state;
    logic [PW-1:0]   r_commit, n_commit;
    logic [PW-1:0]   r_reserve, n_reserve;
    logic [PW-1:0]   r_fill, n_fill;
    logic [PW-1:0]   r_rptr, n_rptr;
    logic [PW-1:0]   r_rcur, n_rcur;
    logic [PW-1:0]   r_rrem, n_rrem;
    logic            r_wr_open, n_wr_open;
    logic            r_rd_open, n_rd_open;
    logic [2:0]      r_cnt, n_cnt;
    logic [LEN_W-1:0] r_len, n_len;
    logic            r_peek, n_peek;
    logic [HW-9:0]   r_hdr, n_hdr;

    logic              r_out_valid, n_out_valid;
    t_status           r_status, n_status;
    logic [LEN_W-1:0]  r_plen, n_plen;
    logic [BYTE_W-1:0] r_rbyte, n_rbyte;
    logic              r_last, n_last;
    logic [LEN_W-1:0]  r_free, n_free;
    logic [LEN_W-1:0]  r_used, n_used;
    logic              r_empty, n_empty;
    logic              r_full, n_full;

    logic              w_mem_we;
    logic [IW-1:0]     w_mem_waddr;
    logic [BYTE_W-1:0] w_mem_wdata;
    logic [IW-1:0]     w_mem_raddr;

    logic              w_load;
    t_status           w_ld_status;
    logic [LEN_W-1:0]  w_ld_plen;
    logic [BYTE_W-1:0] w_ld_rbyte;
    logic              w_ld_last;

    logic              w_slot_free;
    logic [PW-1:0]     w_used;
    logic [PW-1:0]     w_rsv_used;
    logic [CW-1:0]     w_avail;
    logic [CW-1:0]     w_need;
    logic              w_noroom;
    logic [PW-1:0]     w_hw_ptr;
    logic [PW-1:0]     w_hr_ptr;
    logic [HW-1:0]     w_len_hdr;
    logic [HW-1:0]     w_hdr;
    logic [PW-1:0]     w_nused;
    logic [PW-1:0]     w_nfree;

    assign w_slot_free = !r_out_valid || o_out.ready;
    assign w_used      = r_commit - r_rptr;
    assign w_rsv_used  = r_reserve - r_rptr;
    assign w_avail     = CW'(RING_BYTES - 1) - CW'(w_rsv_used);
    assign w_need      = CW'(i_cmd.length) + CW'(HDR_BYTES);
    assign w_noroom    = (w_rsv_used <= PW'(RING_BYTES - 1)) && (w_avail < w_need);
    assign w_hw_ptr    = r_reserve + PW'(r_cnt);
    assign w_hr_ptr    = r_rptr + PW'(r_cnt);
    assign w_len_hdr   = HW'(r_len);
    assign w_hdr       = {r_mem_q, r_hdr};

    always_comb begin
        n_state     = r_state;
        n_commit    = r_commit;
        n_reserve   = r_reserve;
        n_fill      = r_fill;
        n_rptr      = r_rptr;
        n_rcur      = r_rcur;
        n_rrem      = r_rrem;
        n_wr_open   = r_wr_open;
        n_rd_open   = r_rd_open;
        n_cnt       = r_cnt;
        n_len       = r_len;
        n_peek      = r_peek;
        n_hdr       = r_hdr;
        o_pop       = 1'b0;
        w_mem_we    = 1'b0;
        w_mem_waddr = r_fill[IW-1:0];
        w_mem_wdata = i_cmd.data;
        w_mem_raddr = r_rcur[IW-1:0];
        w_load      = 1'b0;
        w_ld_status = ST_OK;
        w_ld_plen   = '0;
        w_ld_rbyte  = '0;
        w_ld_last   = 1'b0;

        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_valid && w_slot_free) begin
                    o_pop  = 1'b1;
                    w_load = 1'b1;
                    unique case (i_cmd.op) inside
                        OP_BEGIN: begin
                            if (r_wr_open) begin
                                w_ld_status = ST_SEQ;
                            end else if (i_cmd.length == '0) begin
                                w_ld_status = ST_ZERO;
                            end else if (w_noroom) begin
                                w_ld_status = ST_NOROOM;
                            end else begin
                                w_load  = 1'b0;
                                n_len   = i_cmd.length;
                                n_cnt   = '0;
                                n_state = S_HWR;
                            end
                        end
                        OP_WRITE: begin
                            if (!r_wr_open) begin
                                w_ld_status = ST_SEQ;
                            end else begin
                                w_mem_we = 1'b1;
                                n_fill   = r_fill + PW'(1);
                                // last payload byte commits the packet
                                if (r_fill + PW'(1) == r_reserve) begin
                                    n_commit  = r_reserve;
                                    n_wr_open = 1'b0;
                                end
                            end
                        end
                        OP_OPEN, OP_PEEK: begin
                            if (i_cmd.op == OP_OPEN && r_rd_open) begin
                                w_ld_status = ST_SEQ;
                            end else if (w_used == '0) begin
                                w_ld_status = ST_EMPTY;
                            end else begin
                                w_load  = 1'b0;
                                n_peek  = (i_cmd.op == OP_PEEK);
                                n_cnt   = '0;
                                n_state = S_HRD;
                            end
                        end
                        OP_READ: begin
                            if (!r_rd_open) begin
                                w_ld_status = ST_SEQ;
                            end else begin
                                // memory read at the read cursor issued here
                                w_load  = 1'b0;
                                n_state = S_BRD;
                            end
                        end
                        OP_SKIP: begin
                            if (r_rd_open) begin
                                w_ld_status = ST_SEQ;
                            end else if (CW'(w_used) < CW'(i_cmd.length)) begin
                                w_ld_status = ST_SKIP;
                            end else begin
                                n_rptr = r_rptr + PW'(i_cmd.length);
                            end
                        end
                        OP_CLEAR: begin
                            n_commit  = '0;
                            n_reserve = '0;
                            n_fill    = '0;
                            n_rptr    = '0;
                            n_rcur    = '0;
                            n_rrem    = '0;
                            n_wr_open = 1'b0;
                            n_rd_open = 1'b0;
                        end
                        default: begin
                        end
                    endcase
                end
            end
            S_HWR: begin
                // header goes out little-endian, one byte a cycle
                w_mem_we    = 1'b1;
                w_mem_waddr = w_hw_ptr[IW-1:0];
                w_mem_wdata = w_len_hdr[8*r_cnt[1:0] +: 8];
                if (r_cnt == 3'd3) begin
                    n_fill      = r_reserve + PW'(HDR_BYTES);
                    n_reserve   = r_reserve + PW'(r_len) + PW'(HDR_BYTES);
                    n_wr_open   = 1'b1;
                    w_load      = 1'b1;
                    w_ld_status = ST_OK;
                    n_state     = S_IDLE;
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_HRD: begin
                // read data arrives in the cycle after its address; shift bytes in
                w_mem_raddr = w_hr_ptr[IW-1:0];
                if (r_cnt != 3'd0 && r_cnt != 3'd4) begin
                    n_hdr = {r_mem_q, r_hdr[HW-9:8]};
                end
                if (r_cnt == 3'd4) begin
                    w_load  = 1'b1;
                    n_state = S_IDLE;
                    if ((HW + 1)'(w_used) < (HW + 1)'(w_hdr) + (HW + 1)'(HDR_BYTES)) begin
                        w_ld_status = ST_INCOMPLETE;
                    end else begin
                        w_ld_status = ST_OK;
                        w_ld_plen   = w_hdr[LEN_W-1:0];
                        if (!r_peek) begin
                            if (w_hdr == '0) begin
                                n_rptr = r_rptr + PW'(HDR_BYTES);
                            end else begin
                                n_rcur    = r_rptr + PW'(HDR_BYTES);
                                n_rrem    = w_hdr[PW-1:0];
                                n_rd_open = 1'b1;
                            end
                        end
                    end
                end else begin
                    n_cnt = r_cnt + 3'd1;
                end
            end
            S_BRD: begin
                w_load     = 1'b1;
                w_ld_rbyte = r_mem_q;
                n_rcur     = r_rcur + PW'(1);
                n_rrem     = r_rrem - PW'(1);
                // advance the read pointer only past the final byte
                if (r_rrem == PW'(1)) begin
                    w_ld_last = 1'b1;
                    n_rptr    = r_rcur + PW'(1);
                    n_rd_open = 1'b0;
                end
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign w_nused = n_commit - n_rptr;
    assign w_nfree = PW'(RING_BYTES - 1) - w_nused;

    always_comb begin
        n_out_valid = r_out_valid && !o_out.ready;
        n_status    = r_status;
        n_plen      = r_plen;
        n_rbyte     = r_rbyte;
        n_last      = r_last;
        n_free      = r_free;
        n_used      = r_used;
        n_empty     = r_empty;
        n_full      = r_full;
        if (w_load) begin
            n_out_valid = 1'b1;
            n_status    = w_ld_status;
            n_plen      = w_ld_plen;
            n_rbyte     = w_ld_rbyte;
            n_last      = w_ld_last;
            n_free      = LEN_W'(w_nfree);
            n_used      = LEN_W'(w_nused);
            n_empty     = (w_nused == '0);
            n_full      = (w_nfree == '0);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_mem[w_mem_waddr] <= w_mem_wdata;
        end
        r_mem_q <= r_mem[w_mem_raddr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_commit    <= '0;
            r_reserve   <= '0;
            r_fill      <= '0;
            r_rptr      <= '0;
            r_rcur      <= '0;
            r_rrem      <= '0;
            r_wr_open   <= 1'b0;
            r_rd_open   <= 1'b0;
            r_cnt       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_commit    <= n_commit;
            r_reserve   <= n_reserve;
            r_fill      <= n_fill;
            r_rptr      <= n_rptr;
            r_rcur      <= n_rcur;
            r_rrem      <= n_rrem;
            r_wr_open   <= n_wr_open;
            r_rd_open   <= n_rd_open;
            r_cnt       <= n_cnt;
            r_out_valid <= n_out_valid;
        end
        r_len   <= n_len;
        r_peek  <= n_peek;
        r_hdr   <= n_hdr;
        r_status <= n_status;
        r_plen  <= n_plen;
        r_rbyte <= n_rbyte;
        r_last  <= n_last;
        r_free  <= n_free;
        r_used  <= n_used;
        r_empty <= n_empty;
        r_full  <= n_full;
    end

    assign o_out.valid         = r_out_valid;
    assign o_out.status        = r_status;
    assign o_out.packet_length = r_plen;
    assign o_out.read_byte     = r_rbyte;
    assign o_out.last_byte     = r_last;
    assign o_out.free_space    = r_free;
    assign o_out.used_space    = r_used;
    assign o_out.ring_empty    = r_empty;
    assign o_out.is_full       = r_full;

endmodule

@@ design/length_prefixed_packet_ring.sv @@
// Length-prefixed packet ring: RING_BYTES bytes of single-port-write memory
// holding packets behind a 4-byte little-endian length header. Every command
// beat on i_in gives exactly one result beat on o_out, in order. Commands pass
// through a two-entry queue into a sequencer that owns the memory, so up to
// two commands are taken while a result waits in the output register. In the
// sequencer, write_byte, skip, clear, unused kinds and all rejected commands are
// answered straight from idle; read_byte goes through a registered memory read;
// a successful begin_write writes four header bytes through the one write port;
// open_read and peek on a non-empty ring read four header bytes through the
// registered read port, then check completeness. Pointers reset to zero; the
// memory has no reset and needs no clearing pass.
`timescale 1ns / 1ps

module length_prefixed_packet_ring import lppr_pkg::*; #(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    lppr_in_if.sink    i_in,
    lppr_out_if.source o_out
);

    logic w_cmd_valid;
    t_cmd w_cmd;
    logic w_pop;

    lppr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in        (i_in),
        .i_pop       (w_pop),
        .o_cmd_valid (w_cmd_valid),
        .o_cmd       (w_cmd)
    );

    lppr_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd_valid (w_cmd_valid),
        .i_cmd       (w_cmd),
        .o_pop       (w_pop),
        .o_out       (o_out)
    );

endmodule

@@ design/lppr_checker.sv @@
// Port-level checks on the packet ring result channel, and the bind that
// attaches them to the top level. Depends on lppr_pkg.
`timescale 1ns / 1ps

module lppr_checker import lppr_pkg::*; #(
    parameter int RING_BYTES = RING_BYTES_DEF
) (
    input logic                i_clk,
    input logic                i_rst_n,
    input logic                i_valid,
    input logic                i_ready,
    input logic [STATUS_W-1:0] i_status,
    input logic [LEN_W-1:0]    i_plen,
    input logic [BYTE_W-1:0]   i_rbyte,
    input logic                i_last,
    input logic [LEN_W-1:0]    i_free,
    input logic [LEN_W-1:0]    i_used,
    input logic                i_empty,
    input logic                i_full
);

    // free and used space always account for the whole ring less one byte
    a_space_sum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> (LEN_W'(i_free + i_used) == LEN_W'(RING_BYTES - 1)))
        else $error("free plus used space does not match ring size");

    a_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid |-> ((!i_full || i_free == '0) &&
                     (!i_empty || (i_used == '0 && i_free == LEN_W'(RING_BYTES - 1)))))
        else $error("empty or full flag disagrees with space counts");

    // a failed command carries no length, byte or last mark
    a_fail_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && i_status != ST_OK) |->
            (!i_last && i_plen == '0 && i_rbyte == '0))
        else $error("failed command returned payload");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !i_ready) |=>
            (i_valid && $stable(i_status) && $stable(i_plen) && $stable(i_rbyte) &&
             $stable(i_last) && $stable(i_free) && $stable(i_used)))
        else $error("stalled result beat changed");

endmodule

bind length_prefixed_packet_ring lppr_checker #(
    .RING_BYTES (RING_BYTES)
) u_lppr_checker (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .i_valid  (o_out.valid),
    .i_ready  (o_out.ready),
    .i_status (o_out.status),
    .i_plen   (o_out.packet_length),
    .i_rbyte  (o_out.read_byte),
    .i_last   (o_out.last_byte),
    .i_free   (o_out.free_space),
    .i_used   (o_out.used_space),
    .i_empty  (o_out.ring_empty),
    .i_full   (o_out.is_full)
);

@@ dv/tb_length_prefixed_packet_ring.sv @@
// Self-checking bench for the length-prefixed packet ring: command beats in, result beats
// compared field by field against a behavioral copy of the ring kept in the bench.
// Depends on lppr_pkg, the channel interfaces in lppr_if.sv and the ring itself.
`timescale 1ns / 1ps

module tb_length_prefixed_packet_ring import lppr_pkg::*; ();

    localparam int RING          = RING_BYTES_DEF;
    localparam int IDX_W         = $clog2(RING);
    localparam int PTR_W         = IDX_W + 1;
    localparam int LIMIT_CYCLES  = 1_000_000;
    localparam int SETTLE_CYCLES = 24;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 3'd7;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [LEN_W-1:0]    packet_length;
        logic [BYTE_W-1:0]   read_byte;
        logic                last_byte;
        logic [LEN_W-1:0]    free_space;
        logic [LEN_W-1:0]    used_space;
        logic                ring_empty;
        logic                is_full;
    } t_ring_result;

    logic i_clk;
    logic i_rst_n;

    lppr_in_if  cmd_if ();
    lppr_out_if res_if ();

    length_prefixed_packet_ring dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (cmd_if),
        .o_out   (res_if)
    );

    // Behavioral copy of the ring
    logic [BYTE_W-1:0] ring_mem [RING];
    logic [PTR_W-1:0]  commit_ptr  = '0;
    logic [PTR_W-1:0]  reserve_ptr = '0;
    logic [PTR_W-1:0]  fill_cur    = '0;
    logic [PTR_W-1:0]  rd_ptr      = '0;
    logic [PTR_W-1:0]  rd_cur      = '0;
    logic [LEN_W-1:0]  rd_left     = '0;
    bit                wr_open     = 1'b0;
    bit                rd_open     = 1'b0;

    t_ring_result pending_results [$];
    int  errors            = 0;
    int  cycle_count       = 0;
    int  cmds_sent         = 0;
    int  packets_committed = 0;
    int  packets_drained   = 0;
    int  full_seen         = 0;
    bit  quiet             = 1'b0;

    initial begin
        foreach (ring_mem[i]) ring_mem[i] = '0;
    end

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [PTR_W-1:0] held_bytes();
        return commit_ptr - rd_ptr;
    endfunction

    // Look at the packet under the read pointer without touching any state
    function automatic t_status head_status(output logic [31:0] hdr);
        logic [PTR_W-1:0] used;
        used = held_bytes();
        hdr  = '0;
        if (used == 0) return ST_EMPTY;
        for (int i = 0; i < HDR_BYTES; i++)
            hdr[8*i +: 8] = ring_mem[IDX_W'(rd_ptr + PTR_W'(i))];
        if (64'(used) < 64'(hdr) + 64'(HDR_BYTES)) return ST_INCOMPLETE;
        return ST_OK;
    endfunction

    function automatic t_ring_result ring_predict(logic [KIND_W-1:0] kind,
                                                  logic [LEN_W-1:0] len,
                                                  logic [BYTE_W-1:0] dbyte);
        t_ring_result     r;
        logic [31:0]      hdr;
        logic [PTR_W-1:0] span;
        logic [PTR_W-1:0] used;
        r.status        = ST_OK;
        r.packet_length = '0;
        r.read_byte     = '0;
        r.last_byte     = 1'b0;
        case (kind)
            KIND_BEGIN: begin
                span = reserve_ptr - rd_ptr;
                if (wr_open) begin
                    r.status = ST_SEQ;
                end else if (len == 0) begin
                    r.status = ST_ZERO;
                end else if (RING - 1 - int'(span) < int'(len) + HDR_BYTES) begin
                    r.status = ST_NOROOM;
                end else begin
                    hdr = 32'(len);
                    for (int i = 0; i < HDR_BYTES; i++)
                        ring_mem[IDX_W'(reserve_ptr + PTR_W'(i))] = hdr[8*i +: 8];
                    fill_cur    = reserve_ptr + PTR_W'(HDR_BYTES);
                    reserve_ptr = reserve_ptr + PTR_W'(len) + PTR_W'(HDR_BYTES);
                    wr_open     = 1'b1;
                end
            end
            KIND_WRITE: begin
                if (!wr_open) begin
                    r.status = ST_SEQ;
                end else begin
                    ring_mem[fill_cur[PTR_W-2:0]] = dbyte;
                    fill_cur = fill_cur + 1'b1;
                    // last payload byte commits the packet
                    if (fill_cur == reserve_ptr) begin
                        commit_ptr = reserve_ptr;
                        wr_open    = 1'b0;
                        packets_committed++;
                    end
                end
            end
            KIND_OPEN: begin
                if (rd_open) begin
                    r.status = ST_SEQ;
                end else begin
                    r.status = head_status(hdr);
                    if (r.status == ST_OK) begin
                        r.packet_length = hdr[LEN_W-1:0];
                        // an empty packet is consumed on the spot
                        if (hdr == 0) begin
                            rd_ptr = rd_ptr + PTR_W'(HDR_BYTES);
                        end else begin
                            rd_cur  = rd_ptr + PTR_W'(HDR_BYTES);
                            rd_left = hdr[LEN_W-1:0];
                            rd_open = 1'b1;
                        end
                    end
                end
            end
            KIND_READ: begin
                if (!rd_open) begin
                    r.status = ST_SEQ;
                end else begin
                    r.read_byte = ring_mem[rd_cur[PTR_W-2:0]];
                    rd_cur  = rd_cur + 1'b1;
                    rd_left = rd_left - 1'b1;
                    if (rd_left == 0) begin
                        r.last_byte = 1'b1;
                        rd_ptr      = rd_cur;
                        rd_open     = 1'b0;
                        packets_drained++;
                    end
                end
            end
            KIND_PEEK: begin
                r.status = head_status(hdr);
                if (r.status == ST_OK) r.packet_length = hdr[LEN_W-1:0];
            end
            KIND_SKIP: begin
                if (rd_open) r.status = ST_SEQ;
                else if (held_bytes() < PTR_W'(len)) r.status = ST_SKIP;
                else rd_ptr = rd_ptr + PTR_W'(len);
            end
            KIND_CLEAR: begin
                commit_ptr  = '0;
                reserve_ptr = '0;
                fill_cur    = '0;
                rd_ptr      = '0;
                rd_cur      = '0;
                rd_left     = '0;
                wr_open     = 1'b0;
                rd_open     = 1'b0;
            end
            default: ;
        endcase
        used         = held_bytes();
        r.used_space = used[LEN_W-1:0];
        r.free_space = 12'(RING - int'(used) - 1);
        r.ring_empty = (used == 0);
        r.is_full    = (RING - int'(used) - 1 == 0);
        if (r.is_full) full_seen++;
        return r;
    endfunction

    task automatic send_cmd(logic [KIND_W-1:0] kind, logic [LEN_W-1:0] len,
                            logic [BYTE_W-1:0] dbyte);
        if (!quiet && $urandom_range(0, 4) == 0) begin
            cmd_if.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge i_clk);
        end
        cmd_if.valid     <= 1'b1;
        cmd_if.kind      <= kind;
        cmd_if.length    <= len;
        cmd_if.data_byte <= dbyte;
        @(posedge i_clk);
        while (!cmd_if.ready) @(posedge i_clk);
        pending_results.push_back(ring_predict(kind, len, dbyte));
        if (kind != KIND_UNUSED) cmds_sent++;
    endtask

    task automatic wait_for_results();
        cmd_if.valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    task automatic check_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want) begin
            $display("%0t: %s mismatch: expected 0x%0h, actual 0x%0h", $time, name, want, got);
            errors++;
        end
    endtask

    // Result side: random stall bursts, none in the quiet phase
    initial begin
        int stall;
        stall = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                res_if.ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 6) == 0) begin
                stall = $urandom_range(0, 11);
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        t_ring_result want;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_if.valid && res_if.ready) begin
                if (pending_results.size() == 0) begin
                    $display("%0t: result beat with nothing expected, status %0d",
                             $time, res_if.status);
                    errors++;
                end else begin
                    want = pending_results.pop_front();
                    check_field("status",        16'(want.status),
                                16'(res_if.status));
                    check_field("packet_length", 16'(want.packet_length),
                                16'(res_if.packet_length));
                    check_field("read_byte",     16'(want.read_byte),
                                16'(res_if.read_byte));
                    check_field("last_byte",     16'(want.last_byte),
                                16'(res_if.last_byte));
                    check_field("free_space",    16'(want.free_space),
                                16'(res_if.free_space));
                    check_field("used_space",    16'(want.used_space),
                                16'(res_if.used_space));
                    check_field("ring_empty",    16'(want.ring_empty),
                                16'(res_if.ring_empty));
                    check_field("is_full",       16'(want.is_full),
                                16'(res_if.is_full));
                end
            end
        end
    end

    initial begin
        while (cycle_count < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("%0t: watchdog expired with %0d results outstanding",
                 $time, pending_results.size());
        $display("[FAIL] regression broken");
        $finish;
    end

    // Every command but clear on an idle ring: rejects, empty answers and the field extremes
    task automatic test_idle_rejects();
        send_cmd(KIND_PEEK,   '0, '0);
        send_cmd(KIND_OPEN,   '0, '0);
        send_cmd(KIND_READ,   '0, '0);
        send_cmd(KIND_WRITE,  '0, 8'hFF);
        send_cmd(KIND_SKIP,   12'hFFF, '0);
        send_cmd(KIND_SKIP,   '0, '0);
        send_cmd(KIND_UNUSED, 12'hFFF, 8'hFF);
        send_cmd(KIND_BEGIN,  '0, '0);
        send_cmd(KIND_BEGIN,  12'hFFF, '0);
    endtask

    // One packet end to end, with the out-of-sequence cases along the way
    task automatic test_single_packet();
        send_cmd(KIND_BEGIN, 12'd3, '0);
        send_cmd(KIND_BEGIN, 12'd3, '0);
        send_cmd(KIND_WRITE, '0, 8'h00);
        send_cmd(KIND_WRITE, '0, 8'hFF);
        send_cmd(KIND_WRITE, '0, 8'h5A);
        send_cmd(KIND_OPEN,  '0, '0);
        send_cmd(KIND_OPEN,  '0, '0);
        send_cmd(KIND_PEEK,  '0, '0);
        send_cmd(KIND_SKIP,  12'd1, '0);
        repeat (3) send_cmd(KIND_READ, '0, '0);
    endtask

    // Skip into a payload so that its bytes act as headers: first zero, then too long
    task automatic test_misaligned_headers();
        send_cmd(KIND_BEGIN, 12'd8, '0);
        for (int i = 0; i < 8; i++) send_cmd(KIND_WRITE, '0, (i == 4) ? 8'h10 : 8'h00);
        send_cmd(KIND_SKIP, 12'(HDR_BYTES), '0);
        send_cmd(KIND_OPEN, '0, '0);
        send_cmd(KIND_PEEK, '0, '0);
        send_cmd(KIND_OPEN, '0, '0);
        send_cmd(KIND_SKIP, 12'(HDR_BYTES), '0);
    endtask

    // Fill the ring with one packet from index 0, then drop it so traffic starts at the end
    task automatic test_fill_to_full();
        send_cmd(KIND_CLEAR, '0, '0);
        send_cmd(KIND_BEGIN, 12'(RING - HDR_BYTES - 1), '0);
        repeat (RING - HDR_BYTES - 1) send_cmd(KIND_WRITE, '0, 8'($urandom_range(0, 255)));
        send_cmd(KIND_BEGIN, 12'd1, '0);
        send_cmd(KIND_PEEK,  '0, '0);
        send_cmd(KIND_SKIP,  12'(RING - 1), '0);
    endtask

    task automatic test_random_traffic(int n_cmds);
        int               target;
        int               pick;
        logic [KIND_W-1:0] kind;
        logic [LEN_W-1:0] len;
        logic [31:0]      hdr;
        t_status          head;
        target = cmds_sent + n_cmds;
        while (cmds_sent < target) begin
            pick = $urandom_range(0, 199);
            len  = 12'($urandom_range(0, 4095));
            if (pick < 2) begin
                send_cmd(KIND_CLEAR, len, 8'($urandom_range(0, 255)));
            end else if (pick < 14) begin
                // noise; a begin here never gets room, so no huge packet starts
                kind = 3'($urandom_range(0, 7));
                if (kind == KIND_BEGIN) len = $urandom_range(0, 1) ? 12'hFFF : 12'h000;
                if (kind == KIND_SKIP && $urandom_range(0, 1))
                    len = 12'($urandom_range(0, held_bytes()));
                if (kind == KIND_CLEAR) kind = KIND_PEEK;
                send_cmd(kind, len, 8'($urandom_range(0, 255)));
            end else if (wr_open && pick < 110) begin
                send_cmd(KIND_WRITE, len, 8'($urandom_range(0, 255)));
            end else if (rd_open && pick < 185) begin
                send_cmd(KIND_READ, len, 8'($urandom_range(0, 255)));
            end else if (!wr_open && pick < 125) begin
                pick = $urandom_range(0, 99);
                if (pick < 85) len = 12'($urandom_range(1, 16));
                else if (pick < 98) len = 12'($urandom_range(17, 200));
                else len = 12'($urandom_range(500, 1200));
                send_cmd(KIND_BEGIN, len, 8'($urandom_range(0, 255)));
            end else if (!rd_open) begin
                head = head_status(hdr);
                if (head == ST_INCOMPLETE)
                    send_cmd(KIND_SKIP, 12'(held_bytes()), '0);
                else if (head == ST_OK && $urandom_range(0, 9) == 0)
                    send_cmd(KIND_SKIP, 12'(hdr + HDR_BYTES), '0);
                else if ($urandom_range(0, 3) == 0)
                    send_cmd(KIND_PEEK, len, '0);
                else
                    send_cmd(KIND_OPEN, len, '0);
            end else begin
                send_cmd(KIND_PEEK, len, '0);
            end
        end
    endtask

    initial begin
        cmd_if.valid     <= 1'b0;
        cmd_if.kind      <= KIND_UNUSED;
        cmd_if.length    <= '0;
        cmd_if.data_byte <= '0;
        i_rst_n          <= 1'b0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_rejects();
        test_single_packet();
        test_misaligned_headers();
        // hold the sender until the ring has answered everything
        wait_for_results();
        test_fill_to_full();
        test_random_traffic(1050);
        quiet = 1'b1;
        test_random_traffic(200);
        wait_for_results();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Ran %0d commands: %0d packets committed, %0d read through their last byte,",
                 cmds_sent, packets_committed, packets_drained);
        $display("the ring reported full %0d times and wrapped past its end.", full_seen);
        if (errors == 0 && pending_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ length_prefixed_packet_ring.f @@
design/lppr_pkg.sv
design/lppr_if.sv
design/lppr_front.sv
design/lppr_back.sv
design/length_prefixed_packet_ring.sv
design/lppr_checker.sv
dv/tb_length_prefixed_packet_ring.sv
